// ----- sv/crc_checked_frame_parser_macros.svh -----
// Assertion macros for the framed packet parser.
// Used by crc_checked_frame_parser.sv; expects clk and rst_n in scope.
`ifndef CRC_CHECKED_FRAME_PARSER_MACROS_SVH
`define CRC_CHECKED_FRAME_PARSER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CCFP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define CCFP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/ccfp_pkg.sv -----
// Shared types, constants and the CRC byte update of the framed packet parser.
// No dependencies; used by crc_checked_frame_parser.sv.
`timescale 1ns / 1ps

package ccfp_pkg;

  typedef enum logic [1:0] {
    ST_NONE    = 2'd0,
    ST_OK      = 2'd1,
    ST_FMT_ERR = 2'd2,
    ST_CRC_ERR = 2'd3
  } status_t;

  localparam int COUNT_WIDTH_DEF = 32;
  localparam int TOTAL_W         = 32;

  // Configuration register indexes
  localparam logic [2:0] CFG_HEAD_FIRST  = 3'd0;
  localparam logic [2:0] CFG_HEAD_SECOND = 3'd1;
  localparam logic [2:0] CFG_VERSION     = 3'd2;
  localparam logic [2:0] CFG_TYPE        = 3'd3;
  localparam logic [2:0] CFG_PAYLOAD_LEN = 3'd4;
  localparam logic [2:0] CFG_POS_MIN     = 3'd5;
  localparam logic [2:0] CFG_POS_MAX     = 3'd6;

  // Configuration reset values
  localparam logic [7:0]         HEAD_FIRST_RST  = 8'hAA;
  localparam logic [7:0]         HEAD_SECOND_RST = 8'h55;
  localparam logic [7:0]         VERSION_RST     = 8'd1;
  localparam logic [7:0]         TYPE_RST        = 8'd1;
  localparam logic [7:0]         PAYLOAD_LEN_RST = 8'd10;
  localparam logic signed [15:0] POS_MIN_RST     = -16'sd1000;
  localparam logic signed [15:0] POS_MAX_RST     = 16'sd1000;

  // Frame byte positions
  localparam logic [4:0] IDX_HEAD1  = 5'd0;
  localparam logic [4:0] IDX_HEAD2  = 5'd1;
  localparam logic [4:0] IDX_VER    = 5'd2;
  localparam logic [4:0] IDX_TYPE   = 5'd3;
  localparam logic [4:0] IDX_LEN    = 5'd4;
  localparam logic [4:0] IDX_SEQ0   = 5'd5;
  localparam logic [4:0] IDX_SEQ1   = 5'd6;
  localparam logic [4:0] IDX_POS0   = 5'd7;
  localparam logic [4:0] IDX_POS1   = 5'd8;
  localparam logic [4:0] IDX_FLAG   = 5'd9;
  localparam logic [4:0] IDX_CONF   = 5'd10;
  localparam logic [4:0] IDX_TS0    = 5'd11;
  localparam logic [4:0] IDX_TS1    = 5'd12;
  localparam logic [4:0] IDX_TS2    = 5'd13;
  localparam logic [4:0] IDX_TS3    = 5'd14;
  localparam logic [4:0] IDX_CRC0   = 5'd15;
  localparam logic [4:0] IDX_CRC1   = 5'd16;
  localparam logic [4:0] IDX_BODY   = 5'd5;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [7:0]  FLAG_MAX = 8'd1;
  localparam logic [7:0]  CONF_MAX = 8'd100;

  // CRC-16/CCITT-FALSE over one byte, MSB first.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

// ----- sv/crc_checked_frame_parser.sv -----
// Framed packet parser: header hunt, CRC-16/CCITT-FALSE check, field decode.
// Depends on ccfp_pkg.sv and crc_checked_frame_parser_macros.svh.
`timescale 1ns / 1ps
`include "crc_checked_frame_parser_macros.svh"

// Usage
//   in_*  : one received byte per transaction (in_valid / in_ready).
//   out_* : one result per accepted byte: status, decoded fields (zero unless
//           status is frame ok) and the three running totals after that byte.
//   cfg_* : register writes (cfg_index, cfg_data); always ready. Write only
//           while no byte is in flight. Indexes beyond the list are ignored.
// Timing
//   A byte waits in the input register, then its result loads the output
//   register once that is free or being taken. One byte per cycle sustained
//   while out_ready stays high; the whole per-byte step (CRC byte update,
//   compares) is one combinational pass between those two registers.
// Stall
//   While out_ready is low the result holds; one more byte is taken into the
//   input register, then in_ready drops until the result is taken.
// Reset
//   Synchronous, active low: pipeline empty, parser hunting, totals zero,
//   configuration at its default values.
module crc_checked_frame_parser #(
  parameter int COUNT_WIDTH = ccfp_pkg::COUNT_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_rx_byte,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_status,
  output logic [15:0]         out_sequence_res,
  output logic signed [15:0]  out_ball_position,
  output logic                out_valid_flag,
  output logic [6:0]          out_confidence,
  output logic [31:0]         out_stamp_ms,
  output logic [31:0]         out_ok_total,
  output logic [31:0]         out_format_err_total,
  output logic [31:0]         out_crc_err_total,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  // configuration
  logic [7:0]         head_first_r, head_second_r, version_r, type_r, len_r;
  logic signed [15:0] pos_min_r, pos_max_r;

  // pipeline control
  logic       s1_valid_r, out_valid_r, load_s2;
  logic [7:0] s1_byte_r;

  // parser state
  logic [4:0]             byte_idx_r, byte_idx_nxt;
  logic [15:0]            crc_r, crc_nxt;
  logic [7:0]             ver_b_r, ver_b_nxt, type_b_r, type_b_nxt;
  logic [15:0]            seq_r, seq_nxt;
  logic [15:0]            pos_r, pos_nxt;
  logic [7:0]             flag_b_r, flag_b_nxt, conf_b_r, conf_b_nxt;
  logic [31:0]            ts_r, ts_nxt;
  logic [7:0]             crc_lo_r, crc_lo_nxt;
  logic [COUNT_WIDTH-1:0] ok_cnt_r, ok_cnt_nxt;
  logic [COUNT_WIDTH-1:0] fmt_cnt_r, fmt_cnt_nxt;
  logic [COUNT_WIDTH-1:0] crc_cnt_r, crc_cnt_nxt;

  // result register
  ccfp_pkg::status_t status_r, status_nxt;
  logic [15:0] o_seq_r, o_seq_nxt;
  logic [15:0] o_pos_r, o_pos_nxt;
  logic        o_flag_r, o_flag_nxt;
  logic [6:0]  o_conf_r, o_conf_nxt;
  logic [31:0] o_ts_r, o_ts_nxt;

  logic range_bad;

  assign cfg_ready = 1'b1;
  assign load_s2   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || load_s2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_first_r  <= ccfp_pkg::HEAD_FIRST_RST;
      head_second_r <= ccfp_pkg::HEAD_SECOND_RST;
      version_r     <= ccfp_pkg::VERSION_RST;
      type_r        <= ccfp_pkg::TYPE_RST;
      len_r         <= ccfp_pkg::PAYLOAD_LEN_RST;
      pos_min_r     <= ccfp_pkg::POS_MIN_RST;
      pos_max_r     <= ccfp_pkg::POS_MAX_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        ccfp_pkg::CFG_HEAD_FIRST:  head_first_r  <= cfg_data[7:0];
        ccfp_pkg::CFG_HEAD_SECOND: head_second_r <= cfg_data[7:0];
        ccfp_pkg::CFG_VERSION:     version_r     <= cfg_data[7:0];
        ccfp_pkg::CFG_TYPE:        type_r        <= cfg_data[7:0];
        ccfp_pkg::CFG_PAYLOAD_LEN: len_r         <= cfg_data[7:0];
        ccfp_pkg::CFG_POS_MIN:     pos_min_r     <= cfg_data;
        ccfp_pkg::CFG_POS_MAX:     pos_max_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign range_bad = (flag_b_r > ccfp_pkg::FLAG_MAX) || (conf_b_r > ccfp_pkg::CONF_MAX) ||
                     ($signed(pos_r) < pos_min_r) || ($signed(pos_r) > pos_max_r);

  // one parser step for the byte in the input register
  always_comb begin
    byte_idx_nxt = byte_idx_r;
    crc_nxt      = crc_r;
    ver_b_nxt    = ver_b_r;
    type_b_nxt   = type_b_r;
    seq_nxt      = seq_r;
    pos_nxt      = pos_r;
    flag_b_nxt   = flag_b_r;
    conf_b_nxt   = conf_b_r;
    ts_nxt       = ts_r;
    crc_lo_nxt   = crc_lo_r;
    ok_cnt_nxt   = ok_cnt_r;
    fmt_cnt_nxt  = fmt_cnt_r;
    crc_cnt_nxt  = crc_cnt_r;
    status_nxt   = ccfp_pkg::ST_NONE;
    o_seq_nxt    = '0;
    o_pos_nxt    = '0;
    o_flag_nxt   = 1'b0;
    o_conf_nxt   = '0;
    o_ts_nxt     = '0;
    if (byte_idx_r inside {[ccfp_pkg::IDX_VER:ccfp_pkg::IDX_TS3]}) begin
      crc_nxt = ccfp_pkg::crc16_byte((byte_idx_r == ccfp_pkg::IDX_VER) ?
                                     ccfp_pkg::CRC_INIT : crc_r, s1_byte_r);
    end
    case (byte_idx_r)
      ccfp_pkg::IDX_HEAD1: begin
        if (s1_byte_r == head_first_r) byte_idx_nxt = ccfp_pkg::IDX_HEAD2;
      end
      ccfp_pkg::IDX_HEAD2: begin
        // a repeated first header byte keeps the partial match
        if (s1_byte_r == head_second_r) byte_idx_nxt = ccfp_pkg::IDX_VER;
        else if (s1_byte_r != head_first_r) byte_idx_nxt = ccfp_pkg::IDX_HEAD1;
      end
      ccfp_pkg::IDX_VER: begin
        ver_b_nxt    = s1_byte_r;
        byte_idx_nxt = ccfp_pkg::IDX_TYPE;
      end
      ccfp_pkg::IDX_TYPE: begin
        type_b_nxt   = s1_byte_r;
        byte_idx_nxt = ccfp_pkg::IDX_LEN;
      end
      ccfp_pkg::IDX_LEN: begin
        if (ver_b_r != version_r || type_b_r != type_r || s1_byte_r != len_r) begin
          fmt_cnt_nxt  = fmt_cnt_r + 1'b1;
          status_nxt   = ccfp_pkg::ST_FMT_ERR;
          byte_idx_nxt = ccfp_pkg::IDX_HEAD1;
        end else begin
          byte_idx_nxt = ccfp_pkg::IDX_BODY;
        end
      end
      ccfp_pkg::IDX_SEQ0: begin seq_nxt[7:0]    = s1_byte_r; byte_idx_nxt = byte_idx_r + 1'b1; end
      ccfp_pkg::IDX_SEQ1: begin seq_nxt[15:8]   = s1_byte_r; byte_idx_nxt = byte_idx_r + 1'b1; end
      ccfp_pkg::IDX_POS0: begin pos_nxt[7:0]    = s1_byte_r; byte_idx_nxt = byte_idx_r + 1'b1; end
      ccfp_pkg::IDX_POS1: begin pos_nxt[15:8]   = s1_byte_r; byte_idx_nxt = byte_idx_r + 1'b1; end
      ccfp_pkg::IDX_FLAG: begin flag_b_nxt      = s1_byte_r; byte_idx_nxt = byte_idx_r + 1'b1; end
      ccfp_pkg::IDX_CONF: begin conf_b_nxt      = s1_byte_r; byte_idx_nxt = byte_idx_r + 1'b1; end
      ccfp_pkg::IDX_TS0:  begin ts_nxt[7:0]     = s1_byte_r; byte_idx_nxt = byte_idx_r + 1'b1; end
      ccfp_pkg::IDX_TS1:  begin ts_nxt[15:8]    = s1_byte_r; byte_idx_nxt = byte_idx_r + 1'b1; end
      ccfp_pkg::IDX_TS2:  begin ts_nxt[23:16]   = s1_byte_r; byte_idx_nxt = byte_idx_r + 1'b1; end
      ccfp_pkg::IDX_TS3:  begin ts_nxt[31:24]   = s1_byte_r; byte_idx_nxt = byte_idx_r + 1'b1; end
      ccfp_pkg::IDX_CRC0: begin crc_lo_nxt      = s1_byte_r; byte_idx_nxt = byte_idx_r + 1'b1; end
      ccfp_pkg::IDX_CRC1: begin
        byte_idx_nxt = ccfp_pkg::IDX_HEAD1;
        if ({s1_byte_r, crc_lo_r} != crc_r) begin
          crc_cnt_nxt = crc_cnt_r + 1'b1;
          status_nxt  = ccfp_pkg::ST_CRC_ERR;
        end else if (range_bad) begin
          fmt_cnt_nxt = fmt_cnt_r + 1'b1;
          status_nxt  = ccfp_pkg::ST_FMT_ERR;
        end else begin
          ok_cnt_nxt  = ok_cnt_r + 1'b1;
          status_nxt  = ccfp_pkg::ST_OK;
          o_seq_nxt   = seq_r;
          o_pos_nxt   = pos_r;
          o_flag_nxt  = flag_b_r[0];
          o_conf_nxt  = conf_b_r[6:0];
          o_ts_nxt    = ts_r;
        end
      end
      default: byte_idx_nxt = ccfp_pkg::IDX_HEAD1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      byte_idx_r  <= ccfp_pkg::IDX_HEAD1;
      ok_cnt_r    <= '0;
      fmt_cnt_r   <= '0;
      crc_cnt_r   <= '0;
      status_r    <= ccfp_pkg::ST_NONE;
    end else begin
      if (in_ready) s1_valid_r <= in_valid;
      if (load_s2) begin
        out_valid_r <= 1'b1;
        byte_idx_r  <= byte_idx_nxt;
        ok_cnt_r    <= ok_cnt_nxt;
        fmt_cnt_r   <= fmt_cnt_nxt;
        crc_cnt_r   <= crc_cnt_nxt;
        status_r    <= status_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers: no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) s1_byte_r <= in_rx_byte;
    if (load_s2) begin
      crc_r    <= crc_nxt;
      ver_b_r  <= ver_b_nxt;
      type_b_r <= type_b_nxt;
      seq_r    <= seq_nxt;
      pos_r    <= pos_nxt;
      flag_b_r <= flag_b_nxt;
      conf_b_r <= conf_b_nxt;
      ts_r     <= ts_nxt;
      crc_lo_r <= crc_lo_nxt;
      o_seq_r  <= o_seq_nxt;
      o_pos_r  <= o_pos_nxt;
      o_flag_r <= o_flag_nxt;
      o_conf_r <= o_conf_nxt;
      o_ts_r   <= o_ts_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_sequence_res  = o_seq_r;
  assign out_ball_position = o_pos_r;
  assign out_valid_flag    = o_flag_r;
  assign out_confidence    = o_conf_r;
  assign out_stamp_ms      = o_ts_r;
  // totals change only when a new result loads, so they match the held result
  assign out_ok_total         = ccfp_pkg::TOTAL_W'(ok_cnt_r);
  assign out_format_err_total = ccfp_pkg::TOTAL_W'(fmt_cnt_r);
  assign out_crc_err_total    = ccfp_pkg::TOTAL_W'(crc_cnt_r);

  `CCFP_ASSERT_NXT(a_ok_count_step, load_s2 && status_nxt == ccfp_pkg::ST_OK,
                   ok_cnt_r == $past(ok_cnt_r) + 1'b1 && status_r == ccfp_pkg::ST_OK,
                   "ok total did not advance with an accepted frame")
  `CCFP_ASSERT_NXT(a_totals_hold, !load_s2,
                   $stable(ok_cnt_r) && $stable(fmt_cnt_r) && $stable(crc_cnt_r),
                   "totals changed without a new result")
  `CCFP_ASSERT_NXT(a_rehunt, load_s2 && status_nxt != ccfp_pkg::ST_NONE,
                   byte_idx_r == ccfp_pkg::IDX_HEAD1,
                   "parser not hunting after a frame verdict")
  `CCFP_ASSERT_IMP(a_fields_zero, out_valid_r && status_r != ccfp_pkg::ST_OK,
                   o_seq_r == 16'd0 && o_ts_r == 32'd0 && o_pos_r == 16'd0,
                   "decoded fields nonzero without an accepted frame")
  `CCFP_ASSERT_IMP(a_idx_range, s1_valid_r, byte_idx_r <= ccfp_pkg::IDX_CRC1,
                   "byte index beyond frame length")

endmodule

// ----- test/crc_checked_frame_parser_test.sv -----
// Self-checking testbench for crc_checked_frame_parser: frame stimulus and a scoreboard class.
// Depends on ccfp_pkg.sv and the parser RTL; nothing else is read.
`timescale 1ns / 1ps

module crc_checked_frame_parser_test;

  localparam int         FRAME_BYTES      = 17;
  localparam int         HEAD_CHECK_BYTES = 5;
  localparam int         PHASE_BYTES      = 95;
  localparam int         IDLE_PCT         = 33;
  localparam int         HOLD_CYCLES      = 90;
  localparam int         MAX_REPORTS      = 40;
  localparam logic [2:0] CFG_SPARE        = 3'd7;

  typedef struct packed {
    ccfp_pkg::status_t  status;
    logic [15:0]        seq;
    logic signed [15:0] pos;
    logic               flag;
    logic [6:0]         conf;
    logic [31:0]        ts;
    logic [31:0]        ok_total;
    logic [31:0]        fmt_total;
    logic [31:0]        crc_total;
  } parse_result_t;

  class frame_tracker;
    logic [7:0]         head_first;
    logic [7:0]         head_second;
    logic [7:0]         version_byte;
    logic [7:0]         type_byte;
    logic [7:0]         payload_len;
    logic signed [15:0] pos_min;
    logic signed [15:0] pos_max;
    int                 byte_pos;
    logic [7:0]         frame [FRAME_BYTES];
    logic [31:0]        ok_cnt;
    logic [31:0]        fmt_cnt;
    logic [31:0]        crc_cnt;
    parse_result_t      pending_results [$];
    int                 errors;

    function new();
      head_first   = ccfp_pkg::HEAD_FIRST_RST;
      head_second  = ccfp_pkg::HEAD_SECOND_RST;
      version_byte = ccfp_pkg::VERSION_RST;
      type_byte    = ccfp_pkg::TYPE_RST;
      payload_len  = ccfp_pkg::PAYLOAD_LEN_RST;
      pos_min      = ccfp_pkg::POS_MIN_RST;
      pos_max      = ccfp_pkg::POS_MAX_RST;
      byte_pos     = 0;
      ok_cnt       = '0;
      fmt_cnt      = '0;
      crc_cnt      = '0;
      errors       = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] data);
      case (idx)
        ccfp_pkg::CFG_HEAD_FIRST:  head_first   = data[7:0];
        ccfp_pkg::CFG_HEAD_SECOND: head_second  = data[7:0];
        ccfp_pkg::CFG_VERSION:     version_byte = data[7:0];
        ccfp_pkg::CFG_TYPE:        type_byte    = data[7:0];
        ccfp_pkg::CFG_PAYLOAD_LEN: payload_len  = data[7:0];
        ccfp_pkg::CFG_POS_MIN:     pos_min      = data;
        ccfp_pkg::CFG_POS_MAX:     pos_max      = data;
        default: ;
      endcase
    endfunction

    // CCITT-FALSE, MSB first, over the version byte through the last timestamp byte
    function logic [15:0] frame_crc(logic [7:0] f [FRAME_BYTES]);
      logic [15:0] crc;
      crc = ccfp_pkg::CRC_INIT;
      for (int i = ccfp_pkg::IDX_VER; i <= ccfp_pkg::IDX_TS3; i++) begin
        crc = crc ^ {f[i], 8'h00};
        for (int b = 0; b < 8; b++) begin
          crc = crc[15] ? ({crc[14:0], 1'b0} ^ ccfp_pkg::CRC_POLY) : {crc[14:0], 1'b0};
        end
      end
      return crc;
    endfunction

    function void take_byte(logic [7:0] rx);
      parse_result_t      r;
      logic [15:0]        rx_crc;
      logic signed [15:0] pos;
      r = '0;
      r.status = ccfp_pkg::ST_NONE;
      if (byte_pos == 0) begin
        if (rx == head_first) begin
          frame[ccfp_pkg::IDX_HEAD1] = rx;
          byte_pos = 1;
        end
      end else if (byte_pos == 1) begin
        // second header byte wins over a repeated first one
        if (rx == head_second) begin
          frame[ccfp_pkg::IDX_HEAD2] = rx;
          byte_pos = 2;
        end else if (rx != head_first) begin
          byte_pos = 0;
        end
      end else begin
        frame[byte_pos] = rx;
        byte_pos++;
        if (byte_pos == HEAD_CHECK_BYTES) begin
          if (frame[ccfp_pkg::IDX_VER] != version_byte ||
              frame[ccfp_pkg::IDX_TYPE] != type_byte ||
              frame[ccfp_pkg::IDX_LEN] != payload_len) begin
            fmt_cnt++;
            r.status = ccfp_pkg::ST_FMT_ERR;
            byte_pos = 0;
          end
        end else if (byte_pos == FRAME_BYTES) begin
          byte_pos = 0;
          rx_crc = {frame[ccfp_pkg::IDX_CRC1], frame[ccfp_pkg::IDX_CRC0]};
          pos = {frame[ccfp_pkg::IDX_POS1], frame[ccfp_pkg::IDX_POS0]};
          if (rx_crc != frame_crc(frame)) begin
            crc_cnt++;
            r.status = ccfp_pkg::ST_CRC_ERR;
          end else if (frame[ccfp_pkg::IDX_FLAG] > ccfp_pkg::FLAG_MAX ||
                       frame[ccfp_pkg::IDX_CONF] > ccfp_pkg::CONF_MAX ||
                       pos < pos_min || pos > pos_max) begin
            fmt_cnt++;
            r.status = ccfp_pkg::ST_FMT_ERR;
          end else begin
            ok_cnt++;
            r.status = ccfp_pkg::ST_OK;
            r.seq = {frame[ccfp_pkg::IDX_SEQ1], frame[ccfp_pkg::IDX_SEQ0]};
            r.pos = pos;
            r.flag = frame[ccfp_pkg::IDX_FLAG][0];
            r.conf = frame[ccfp_pkg::IDX_CONF][6:0];
            r.ts = {frame[ccfp_pkg::IDX_TS3], frame[ccfp_pkg::IDX_TS2],
                    frame[ccfp_pkg::IDX_TS1], frame[ccfp_pkg::IDX_TS0]};
          end
        end
      end
      r.ok_total = ok_cnt;
      r.fmt_total = fmt_cnt;
      r.crc_total = crc_cnt;
      pending_results.push_back(r);
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: %s expected 0x%0h got 0x%0h", $time, field, want, got);
      end
    endfunction

    function void check_result(parse_result_t got);
      parse_result_t want;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result with nothing expected, status %0d", $time, got.status);
        return;
      end
      want = pending_results.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("sequence_res", want.seq, got.seq);
      compare_field("ball_position", want.pos, got.pos);
      compare_field("valid_flag", want.flag, got.flag);
      compare_field("confidence", want.conf, got.conf);
      compare_field("stamp_ms", want.ts, got.ts);
      compare_field("ok_total", want.ok_total, got.ok_total);
      compare_field("format_err_total", want.fmt_total, got.fmt_total);
      compare_field("crc_err_total", want.crc_total, got.crc_total);
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         in_rx_byte = 8'h00;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         out_status;
  logic [15:0]        out_sequence_res;
  logic signed [15:0] out_ball_position;
  logic               out_valid_flag;
  logic [6:0]         out_confidence;
  logic [31:0]        out_stamp_ms;
  logic [31:0]        out_ok_total;
  logic [31:0]        out_format_err_total;
  logic [31:0]        out_crc_err_total;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = 3'd0;
  logic [15:0]        cfg_data = 16'h0000;

  frame_tracker tracker;
  logic [7:0]   frame_buf [FRAME_BYTES];
  int           phase_bytes;
  int           in_idle_pct = IDLE_PCT;
  int           out_idle_pct = IDLE_PCT;
  bit           hold_req = 1'b0;
  int           hold_left = 0;

  crc_checked_frame_parser uut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Check each result transaction, then decide out_ready for the next edge.
  always @(posedge clk) begin : result_monitor
    parse_result_t got;
    if (rst_n && out_valid && out_ready) begin
      got.status    = ccfp_pkg::status_t'(out_status);
      got.seq       = out_sequence_res;
      got.pos       = out_ball_position;
      got.flag      = out_valid_flag;
      got.conf      = out_confidence;
      got.ts        = out_stamp_ms;
      got.ok_total  = out_ok_total;
      got.fmt_total = out_format_err_total;
      got.crc_total = out_crc_err_total;
      tracker.check_result(got);
    end
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    tracker.take_byte(b);
    phase_bytes++;
  endtask

  task automatic send_frame(input int n);
    for (int i = 0; i < n; i++) send_byte(frame_buf[i]);
  endtask

  function automatic void make_frame(logic [15:0] seq, logic signed [15:0] pos,
                                     logic [7:0] flag, logic [7:0] conf, logic [31:0] ts);
    frame_buf[ccfp_pkg::IDX_HEAD1] = tracker.head_first;
    frame_buf[ccfp_pkg::IDX_HEAD2] = tracker.head_second;
    frame_buf[ccfp_pkg::IDX_VER]   = tracker.version_byte;
    frame_buf[ccfp_pkg::IDX_TYPE]  = tracker.type_byte;
    frame_buf[ccfp_pkg::IDX_LEN]   = tracker.payload_len;
    {frame_buf[ccfp_pkg::IDX_SEQ1], frame_buf[ccfp_pkg::IDX_SEQ0]} = seq;
    {frame_buf[ccfp_pkg::IDX_POS1], frame_buf[ccfp_pkg::IDX_POS0]} = pos;
    frame_buf[ccfp_pkg::IDX_FLAG] = flag;
    frame_buf[ccfp_pkg::IDX_CONF] = conf;
    {frame_buf[ccfp_pkg::IDX_TS3], frame_buf[ccfp_pkg::IDX_TS2],
     frame_buf[ccfp_pkg::IDX_TS1], frame_buf[ccfp_pkg::IDX_TS0]} = ts;
    {frame_buf[ccfp_pkg::IDX_CRC1], frame_buf[ccfp_pkg::IDX_CRC0]} =
      tracker.frame_crc(frame_buf);
  endfunction

  task automatic send_random_frame();
    int                 kind;
    int                 lo;
    int                 hi;
    int                 n;
    int                 at;
    logic signed [15:0] pos;
    logic [7:0]         flag;
    logic [7:0]         conf;
    logic [7:0]         b;
    kind = $urandom_range(99);
    lo = int'(tracker.pos_min);
    hi = int'(tracker.pos_max);
    flag = 8'($urandom_range(1));
    conf = ($urandom_range(3) == 0) ?
           ($urandom_range(1) ? ccfp_pkg::CONF_MAX : 8'd0) :
           8'($urandom_range(100));
    if (lo <= hi) begin
      case ($urandom_range(3))
        0:       pos = 16'(lo);
        1:       pos = 16'(hi);
        default: pos = 16'(lo + int'($urandom_range(hi - lo)));
      endcase
    end else begin
      pos = 16'($urandom);
    end
    if (kind >= 72 && kind < 84) begin
      // range violation: flag, confidence or position
      case ($urandom_range(2))
        0: flag = 8'($urandom_range(2, 255));
        1: conf = 8'($urandom_range(101, 255));
        default: begin
          if (lo > -32768 && (hi >= 32767 || $urandom_range(1)))
            pos = 16'(-32768 + int'($urandom_range(lo + 32767)));
          else if (hi < 32767)
            pos = 16'(hi + 1 + int'($urandom_range(32766 - hi)));
          else
            flag = 8'($urandom_range(2, 255));
        end
      endcase
    end
    make_frame(16'($urandom), pos, flag, conf, $urandom);
    // a few repeated first header bytes ahead of the frame
    if (tracker.head_first != tracker.head_second && $urandom_range(3) == 0) begin
      n = $urandom_range(1, 3);
      repeat (n) send_byte(tracker.head_first);
    end
    if (kind < 50 || (kind >= 72 && kind < 84)) begin
      send_frame(FRAME_BYTES);
    end else if (kind < 62) begin
      at = $urandom_range(ccfp_pkg::IDX_SEQ0, ccfp_pkg::IDX_CRC1);
      frame_buf[at] = frame_buf[at] ^ 8'($urandom_range(1, 255));
      send_frame(FRAME_BYTES);
    end else if (kind < 72) begin
      at = $urandom_range(ccfp_pkg::IDX_VER, ccfp_pkg::IDX_LEN);
      frame_buf[at] = frame_buf[at] ^ 8'($urandom_range(1, 255));
      send_frame(HEAD_CHECK_BYTES);
    end else if (kind < 92) begin
      send_byte(tracker.head_first);
      do b = 8'($urandom); while (b == tracker.head_first || b == tracker.head_second);
      send_byte(b);
    end else begin
      n = $urandom_range(1, 6);
      repeat (n) send_byte(8'($urandom));
    end
  endtask

  task automatic run_random_frames();
    phase_bytes = 0;
    while (phase_bytes < PHASE_BYTES) send_random_frame();
  endtask

  // Drop valid, wait out every expected result and the pipeline latency.
  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(input logic [7:0] hf, hs, ver, typ, plen,
                           input logic signed [15:0] pmin, pmax);
    logic [2:0]  idx [8];
    logic [15:0] val [8];
    idx = '{ccfp_pkg::CFG_HEAD_FIRST, ccfp_pkg::CFG_HEAD_SECOND, ccfp_pkg::CFG_VERSION,
            ccfp_pkg::CFG_TYPE, ccfp_pkg::CFG_PAYLOAD_LEN, ccfp_pkg::CFG_POS_MIN,
            ccfp_pkg::CFG_POS_MAX, CFG_SPARE};
    // upper data bits of the byte registers are junk and must be dropped
    val = '{{8'($urandom), hf}, {8'($urandom), hs}, {8'($urandom), ver},
            {8'($urandom), typ}, {8'($urandom), plen}, pmin, pmax, 16'($urandom)};
    cfg_valid <= 1'b1;
    foreach (idx[i]) begin
      cfg_index <= idx[i];
      cfg_data <= val[i];
      do @(posedge clk); while (!cfg_ready);
      tracker.write_reg(idx[i], val[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic signed [15:0] a;
    logic signed [15:0] b;
    tracker = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // header mismatch, repeated first byte then bad version, one clean frame at the limits
    send_byte(ccfp_pkg::HEAD_FIRST_RST);
    send_byte(8'h00);
    send_byte(ccfp_pkg::HEAD_FIRST_RST);
    send_byte(ccfp_pkg::HEAD_FIRST_RST);
    send_byte(ccfp_pkg::HEAD_SECOND_RST);
    send_byte(ccfp_pkg::VERSION_RST + 8'd1);
    send_byte(ccfp_pkg::TYPE_RST);
    send_byte(ccfp_pkg::PAYLOAD_LEN_RST);
    make_frame(16'hFFFF, ccfp_pkg::POS_MAX_RST, ccfp_pkg::FLAG_MAX, ccfp_pkg::CONF_MAX,
               32'hFFFF_FFFF);
    send_frame(FRAME_BYTES);

    // stall the output long enough to back up the input
    hold_req = 1'b1;
    run_random_frames();
    drain();

    configure(8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF, 16'sh8000, 16'sh7FFF);
    run_random_frames();
    drain();

    // equal header bytes and a single-point position window
    configure(8'h7E, 8'h7E, 8'h80, 8'h7F, 8'h01, -16'sd1, -16'sd1);
    run_random_frames();
    drain();

    // empty position window
    configure(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
              16'sd500, -16'sd500);
    hold_req = 1'b1;
    run_random_frames();
    drain();

    a = 16'($urandom);
    b = 16'($urandom);
    if (a > b)
      configure(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), b, a);
    else
      configure(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), a, b);
    in_idle_pct = 0;
    out_idle_pct = 0;
    run_random_frames();
    in_idle_pct = IDLE_PCT;
    out_idle_pct = IDLE_PCT;
    run_random_frames();
    drain();

    if (tracker.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
